// File: rtl/core/dffc_pkg.sv
// Shared constants and command/status types for the depth frame false-color block.
`timescale 1ns / 1ps

package dffc_pkg;

    localparam int DEPTH_BITS = 16;
    localparam int SAMPLE_W   = 16;
    localparam int QUOT_BITS  = 8;
    localparam int PROD_W     = DEPTH_BITS + QUOT_BITS;
    localparam int CNT_W      = $clog2(QUOT_BITS);

    localparam logic [QUOT_BITS-1:0] FULL_SCALE = '1;

    typedef struct packed {
        logic scan;
        logic load;
        logic step;
        logic emit;
    } dffc_cmd_t;

    typedef struct packed {
        logic special;
    } dffc_status_t;

endpackage

// File: rtl/core/dffc_if.sv
// Request channel interfaces for depth samples in and color pixels out.
`timescale 1ns / 1ps

interface dffc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [dffc_pkg::SAMPLE_W-1:0] depth_sample;
    logic                          frame_end;

    modport source (output valid, output action, output depth_sample, output frame_end,
                    input ready);
    modport sink (input valid, input action, input depth_sample, input frame_end,
                  output ready);
endinterface

interface dffc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       last_pixel;

    modport source (output valid, output blue, output green, output red, output alpha,
                    output last_pixel, input ready);
    modport sink (input valid, input blue, input green, input red, input alpha,
                  input last_pixel, output ready);
endinterface

// File: rtl/core/dffc_ctrl.sv
// Controller state machine that sequences scan, divide and pixel output.
`timescale 1ns / 1ps

module dffc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_action,
    output logic                   in_ready,
    input  logic                   out_ready,
    output logic                   out_valid,
    input  dffc_pkg::dffc_status_t status,
    output dffc_pkg::dffc_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [dffc_pkg::CNT_W-1:0]   count_reg;
    logic [dffc_pkg::CNT_W-1:0]   count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_action)
                    begin
                        cmd.load   = 1'b1;
                        count_next = '0;
                        state_next = status.special ? ST_FINISH : ST_DIV;
                    end
                    else
                    begin
                        cmd.scan = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.step   = 1'b1;
                count_next = count_reg + 1'b1;
                if (count_reg == dffc_pkg::CNT_W'(dffc_pkg::QUOT_BITS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/dffc_datapath.sv
// Datapath: frame maximum, radix-2 restoring divider and pixel output registers.
`timescale 1ns / 1ps

module dffc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dffc_pkg::dffc_cmd_t           cmd,
    input  logic [dffc_pkg::SAMPLE_W-1:0] depth_sample,
    input  logic                          frame_end,
    output dffc_pkg::dffc_status_t        status,
    output logic [7:0]                    blue,
    output logic [7:0]                    red,
    output logic [7:0]                    alpha,
    output logic                          last_pixel
);

    localparam int DB = dffc_pkg::DEPTH_BITS;
    localparam int QB = dffc_pkg::QUOT_BITS;

    logic [DB-1:0]                 max_reg;
    logic [DB-1:0]                 den_reg;
    logic [DB-1:0]                 rem_reg;
    logic [QB-1:0]                 quo_reg;
    logic                          zero_reg;
    logic                          sat_reg;
    logic                          last_reg;
    logic [7:0]                    blue_reg;
    logic [7:0]                    red_reg;
    logic [7:0]                    alpha_reg;
    logic                          last_pixel_reg;

    logic [DB-1:0]                 d_in;
    logic [dffc_pkg::PROD_W-1:0]   prod;
    logic [DB:0]                   trial;
    logic [DB+1:0]                 diff;
    logic                          fits;

    assign d_in  = depth_sample[DB-1:0];
    assign prod  = {d_in, QB'(0)} - dffc_pkg::PROD_W'(d_in);
    assign trial = {rem_reg, quo_reg[QB-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign fits  = ~diff[DB+1];

    assign status.special = (d_in == '0) || (d_in >= max_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '0;
        end
        else if (cmd.scan && (d_in > max_reg))
        begin
            max_reg <= d_in;
        end
        else if (cmd.emit && last_reg)
        begin
            max_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            den_reg  <= max_reg;
            rem_reg  <= prod[dffc_pkg::PROD_W-1:QB];
            quo_reg  <= prod[QB-1:0];
            zero_reg <= (d_in == '0);
            sat_reg  <= (d_in >= max_reg);
            last_reg <= frame_end;
        end
        else if (cmd.step)
        begin
            rem_reg <= fits ? diff[DB-1:0] : trial[DB-1:0];
            quo_reg <= {quo_reg[QB-2:0], fits};
        end
        if (cmd.emit)
        begin
            last_pixel_reg <= last_reg;
            if (zero_reg)
            begin
                blue_reg  <= '0;
                red_reg   <= '0;
                alpha_reg <= dffc_pkg::FULL_SCALE;
            end
            else if (sat_reg)
            begin
                blue_reg  <= '0;
                red_reg   <= dffc_pkg::FULL_SCALE;
                alpha_reg <= '0;
            end
            else
            begin
                red_reg <= quo_reg;
                if (rem_reg == '0)
                begin
                    blue_reg  <= dffc_pkg::FULL_SCALE - quo_reg;
                    alpha_reg <= dffc_pkg::FULL_SCALE - quo_reg;
                end
                else
                begin
                    blue_reg  <= dffc_pkg::FULL_SCALE - quo_reg - 8'd1;
                    alpha_reg <= dffc_pkg::FULL_SCALE - quo_reg - 8'd1;
                end
            end
        end
    end

    assign blue       = blue_reg;
    assign red        = red_reg;
    assign alpha      = alpha_reg;
    assign last_pixel = last_pixel_reg;

endmodule

// File: rtl/core/depth_frame_false_color_top.sv
// Top level of the depth frame false-color block.
//
//  channel | dir | handshake       | payload
//  depth   | in  | valid / ready   | action, depth_sample, frame_end
//  color   | out | valid / ready   | blue, green, red, alpha, last_pixel
//
// A scan request folds its sample into the frame maximum. A convert request loads the operands,
// steps the radix-2 restoring divider once per quotient bit, then writes the output register.
// Zero or saturating depths skip the divider.
// The output register holds a finished pixel while the next request is accepted.
// Reset clears the frame maximum and the controller; a stalled output holds the
// divider result until the pixel register frees.
`timescale 1ns / 1ps

module depth_frame_false_color_top (
    input logic        clk,
    input logic        rst_n,
    dffc_in_if.sink    depth,
    dffc_out_if.source color
);

    dffc_pkg::dffc_cmd_t    cmd;
    dffc_pkg::dffc_status_t status;

    dffc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (depth.valid),
        .in_action (depth.action),
        .in_ready  (depth.ready),
        .out_ready (color.ready),
        .out_valid (color.valid),
        .status    (status),
        .cmd       (cmd)
    );

    dffc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .depth_sample (depth.depth_sample),
        .frame_end    (depth.frame_end),
        .status       (status),
        .blue         (color.blue),
        .red          (color.red),
        .alpha        (color.alpha),
        .last_pixel   (color.last_pixel)
    );

    assign color.green = '0;

endmodule

// File: rtl/core/dffc_checker.sv
// Port-level assertions for the depth frame false-color block and their bind.
`timescale 1ns / 1ps

module dffc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       depth_valid,
    input logic       depth_ready,
    input logic       depth_action,
    input logic       color_valid,
    input logic       color_ready,
    input logic [7:0] blue,
    input logic [7:0] green,
    input logic [7:0] red,
    input logic [7:0] alpha,
    input logic       last_pixel
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && !color_ready |=> color_valid && $stable(blue) && $stable(red)
        && $stable(alpha) && $stable(last_pixel))
        else $error("Stalled pixel changed or dropped.");

    a_green_zero: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid |-> green == 8'd0)
        else $error("Green byte is not zero.");

    a_alpha_blue: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && (alpha != blue) |-> red == 8'd0 && blue == 8'd0 && alpha == 8'd255)
        else $error("Alpha differs from blue outside the missing-depth case.");

    a_red_blue_sum: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid |-> ({1'b0, red} + {1'b0, blue}) <= 9'd255)
        else $error("Red and blue exceed full scale together.");

    a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        depth_valid && depth_ready && depth_action |=> !depth_ready)
        else $error("Convert request did not occupy the block.");

endmodule

bind depth_frame_false_color_top dffc_checker u_dffc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .depth_valid  (depth.valid),
    .depth_ready  (depth.ready),
    .depth_action (depth.action),
    .color_valid  (color.valid),
    .color_ready  (color.ready),
    .blue         (color.blue),
    .green        (color.green),
    .red          (color.red),
    .alpha        (color.alpha),
    .last_pixel   (color.last_pixel)
);

// File: bench/dffc_tb_pkg.sv
// Request codes shared by the depth frame false-color testbench files.
`timescale 1ns / 1ps

package dffc_tb_pkg;

    typedef enum logic
    {
        ACT_SCAN    = 1'b0,
        ACT_CONVERT = 1'b1
    } depth_action_t;

endpackage

// File: bench/dffc_color_checker.sv
// Checker that predicts each color pixel from the depth requests and compares it.
`timescale 1ns / 1ps

module dffc_color_checker (
    input  logic clk,
    input  logic rst_n,
    dffc_in_if   depth,
    dffc_out_if  color,
    output int   errors,
    output int   in_flight,
    output int   pixels_seen
);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       last_pixel;
    } pixel_t;

    localparam logic [31:0] DEPTH_MASK = (32'd1 << dffc_pkg::DEPTH_BITS) - 32'd1;

    logic [15:0] frame_peak;
    pixel_t      pixel_q[$];

    function automatic pixel_t paint_pixel(logic [15:0] d, logic [15:0] peak, logic fe);
        pixel_t      p;
        logic [31:0] scale;
        scale        = 32'(dffc_pkg::FULL_SCALE);
        p.green      = 8'd0;
        p.last_pixel = fe;
        if (d == 16'd0)
        begin
            p.blue  = 8'd0;
            p.red   = 8'd0;
            p.alpha = dffc_pkg::FULL_SCALE;
        end
        else if (d >= peak)
        begin
            p.red   = dffc_pkg::FULL_SCALE;
            p.blue  = 8'd0;
            p.alpha = 8'd0;
        end
        else
        begin
            p.red   = 8'((scale * 32'(d)) / 32'(peak));
            p.blue  = 8'((scale * 32'(peak - d)) / 32'(peak));
            p.alpha = p.blue;
        end
        return p;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t      want;
        logic [15:0] d;
        if (!rst_n)
        begin
            frame_peak = 16'd0;
            pixel_q.delete();
            in_flight <= 0;
        end
        else
        begin
            if (color.valid && color.ready)
            begin
                pixels_seen++;
                if (pixel_q.size() == 0)
                begin
                    errors++;
                    $error("color: pixel arrived with no request waiting");
                end
                else
                begin
                    want = pixel_q.pop_front();
                    check_field("blue", want.blue, color.blue);
                    check_field("green", want.green, color.green);
                    check_field("red", want.red, color.red);
                    check_field("alpha", want.alpha, color.alpha);
                    check_field("last_pixel", want.last_pixel, color.last_pixel);
                end
            end
            if (depth.valid && depth.ready)
            begin
                d = 16'(32'(depth.depth_sample) & DEPTH_MASK);
                if (depth.action == dffc_tb_pkg::ACT_SCAN)
                begin
                    if (d > frame_peak)
                        frame_peak = d;
                end
                else
                begin
                    pixel_q.push_back(paint_pixel(d, frame_peak, depth.frame_end));
                    if (depth.frame_end)
                        frame_peak = 16'd0;
                end
            end
            in_flight <= pixel_q.size();
        end
    end

endmodule

// File: bench/tb_top.sv
// Testbench top that drives depth requests, stalls the pixel output and reports the verdict.
`timescale 1ns / 1ps

module tb_top;

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    int   errors;
    int   in_flight;
    int   pixels_seen;
    int   scans_sent;
    int   converts_sent;
    int   frames_sent;
    int   sink_hold;

    dffc_in_if  depth();
    dffc_out_if color();

    depth_frame_false_color_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .depth (depth),
        .color (color)
    );

    dffc_color_checker u_color_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .depth       (depth),
        .color       (color),
        .errors      (errors),
        .in_flight   (in_flight),
        .pixels_seen (pixels_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_depth(logic [15:0] limit);
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return limit;
            2: return (limit > 16'd1) ? limit - 16'd1 : 16'd1;
            3: return 16'($urandom);
            4: return 16'd1;
            default: return 16'($urandom_range(1, limit));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            color.ready <= 1'b0;
            sink_hold   <= 0;
        end
        else if (sink_hold != 0)
        begin
            sink_hold <= sink_hold - 1;
        end
        else if (calm)
        begin
            color.ready <= 1'b1;
        end
        else
        begin
            color.ready <= ($urandom_range(0, 9) < 7);
            sink_hold   <= idle_len();
        end
    end

    task automatic send_sample(dffc_tb_pkg::depth_action_t act, logic [15:0] d, logic fe);
        int gap;
        gap = idle_len();
        if (gap != 0)
        begin
            depth.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        depth.valid        <= 1'b1;
        depth.action       <= act;
        depth.depth_sample <= d;
        depth.frame_end    <= fe;
        do
            @(posedge clk);
        while (!depth.ready);
        if (act == dffc_tb_pkg::ACT_SCAN)
            scans_sent++;
        else
            converts_sent++;
    endtask

    task automatic send_frame();
        logic [15:0] limit;
        int          n_scan;
        int          n_conv;
        bit          broken;
        calm   = ($urandom_range(0, 4) == 0);
        broken = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 3))
            0: limit = 16'hFFFF;
            1: limit = 16'($urandom_range(1, 255));
            default: limit = 16'($urandom_range(1, 65535));
        endcase
        n_scan = broken ? $urandom_range(0, 3) : $urandom_range(1, 16);
        n_conv = $urandom_range(1, 16);
        for (int i = 0; i < n_scan; i++)
            send_sample(dffc_tb_pkg::ACT_SCAN, pick_depth(limit),
                        broken ? 1'($urandom_range(0, 1)) : (i == n_scan - 1));
        for (int i = 0; i < n_conv; i++)
            send_sample(dffc_tb_pkg::ACT_CONVERT, pick_depth(limit),
                        broken ? ($urandom_range(0, 3) == 0) : (i == n_conv - 1));
        frames_sent++;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        calm               = 1'b0;
        depth.valid        = 1'b0;
        depth.action       = dffc_tb_pkg::ACT_SCAN;
        depth.depth_sample = 16'd0;
        depth.frame_end    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no scan yet the maximum is zero, so any nonzero depth saturates.
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'd0, 1'b0);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'd5, 1'b0);
        send_sample(dffc_tb_pkg::ACT_SCAN, 16'd1000, 1'b1);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'd0, 1'b0);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'd1, 1'b0);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'd999, 1'b0);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'd1000, 1'b0);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'd1001, 1'b0);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'd500, 1'b0);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'hFFFF, 1'b1);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'd7, 1'b1);
        send_sample(dffc_tb_pkg::ACT_SCAN, 16'hFFFF, 1'b0);
        send_sample(dffc_tb_pkg::ACT_SCAN, 16'd1, 1'b1);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'd1, 1'b0);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'hFFFE, 1'b0);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'h8000, 1'b0);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'hFFFF, 1'b1);
        send_sample(dffc_tb_pkg::ACT_SCAN, 16'd1, 1'b1);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'd1, 1'b0);
        send_sample(dffc_tb_pkg::ACT_CONVERT, 16'd0, 1'b1);

        while (scans_sent + converts_sent < 1520)
            send_frame();
        depth.valid <= 1'b0;

        do
            @(posedge clk);
        while (in_flight != 0);
        repeat (20) @(posedge clk);

        $display("tb_top: %0d frames, %0d scan and %0d convert requests sent",
                 frames_sent, scans_sent, converts_sent);
        $display("tb_top: %0d pixels compared, %0d mismatches", pixels_seen, errors);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("tb_top: timeout with %0d pixels still expected", in_flight);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
